// ===== hdl/pcp_pkg.sv =====
// Shared types, codes and constants for the pinhole camera projection unit.
package pcp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_W         = 64;   // numerator width into the divider
  localparam int DEN_W         = 31;   // divisor width (focal length or Z)
  localparam int DIV_BITS      = 2;    // quotient bits resolved per divider stage
  localparam int DIV_STAGES    = NUM_W / DIV_BITS;
  localparam int SUM_W         = 66;   // signed quotient plus offset

  // Operation codes
  localparam logic [1:0] OP_PROJ     = 2'd0;
  localparam logic [1:0] OP_PROJ_CHK = 2'd1;
  localparam logic [1:0] OP_UNPROJ   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONPOS = 2'd1;
  localparam logic [1:0] ST_OOB    = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_FOCAL_X      = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y      = 3'd1;
  localparam logic [2:0] REG_CENTER_X     = 3'd2;
  localparam logic [2:0] REG_CENTER_Y     = 3'd3;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;

  // Reset values
  localparam logic [30:0]        RST_FOCAL_X  = 31'd34406400;
  localparam logic [30:0]        RST_FOCAL_Y  = 31'd34406400;
  localparam logic signed [31:0] RST_CENTER_X = 32'sd20938752;
  localparam logic signed [31:0] RST_CENTER_Y = 32'sd15695872;
  localparam logic [15:0]        RST_WIDTH    = 16'd640;
  localparam logic [15:0]        RST_HEIGHT   = 16'd480;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic signed [31:0] depth;
  } pcp_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         status;
  } pcp_out_t;

  typedef struct packed {
    logic [30:0]        focal_x;
    logic [30:0]        focal_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [15:0]        image_width;
    logic [15:0]        image_height;
  } pcp_cfg_t;

  // Control that rides alongside the divider pipeline
  typedef struct packed {
    logic               vld;
    logic [1:0]         op;
    logic               bad;     // Z or depth not positive
    logic               neg_x;
    logic               neg_y;
    logic               zero_x;  // numerator is zero
    logic               zero_y;
    logic signed [31:0] depth;
  } pcp_side_t;

endpackage

// ===== hdl/pcp_div.sv =====
// Pipelined restoring divider, a fixed number of quotient bits per stage.
module pcp_div (
  input  logic                      clk,
  input  logic [pcp_pkg::NUM_W-1:0] num,
  input  logic [pcp_pkg::DEN_W-1:0] den,
  output logic [pcp_pkg::NUM_W-1:0] quot
);

  localparam int NW = pcp_pkg::NUM_W;
  localparam int DW = pcp_pkg::DEN_W;
  localparam int NS = pcp_pkg::DIV_STAGES;

  // work holds the remaining dividend bits shifting out and quotient bits in
  logic [DW-1:0] rem  [0:NS];
  logic [NW-1:0] work [0:NS];
  logic [DW-1:0] dsor [0:NS];

  assign rem[0]  = '0;
  assign work[0] = num;
  assign dsor[0] = den;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW-1:0] r_next;
    logic [NW-1:0] w_next;
    logic [DW:0]   shifted;

    // resolve DIV_BITS quotient bits
    always_comb begin
      r_next  = rem[s];
      w_next  = work[s];
      shifted = '0;
      for (int b = 0; b < pcp_pkg::DIV_BITS; b++) begin
        shifted = {r_next, w_next[NW-1]};
        w_next  = {w_next[NW-2:0], 1'b0};
        if (shifted >= {1'b0, dsor[s]}) begin
          shifted   = shifted - {1'b0, dsor[s]};
          w_next[0] = 1'b1;
        end
        r_next = shifted[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      rem[s+1]  <= r_next;
      work[s+1] <= w_next;
      dsor[s+1] <= dsor[s];
    end
  end

  assign quot = work[NS];

endmodule

// ===== hdl/pcp_front.sv =====
// Operand setup and numerator multiply ahead of the dividers.
module pcp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  pcp_pkg::pcp_in_t          cmd,
  input  pcp_pkg::pcp_cfg_t         cfg,
  output logic [pcp_pkg::NUM_W-1:0] num_x,
  output logic [pcp_pkg::NUM_W-1:0] num_y,
  output logic [pcp_pkg::DEN_W-1:0] den_x,
  output logic [pcp_pkg::DEN_W-1:0] den_y,
  output pcp_pkg::pcp_side_t        side
);

  // stage 1 registers
  pcp_pkg::pcp_side_t        s1_side;
  logic [32:0]               s1_mag_x, s1_mag_y;
  logic [30:0]               s1_mul_x, s1_mul_y;
  logic [pcp_pkg::DEN_W-1:0] s1_den_x, s1_den_y;

  // stage 1 combinational
  pcp_pkg::pcp_side_t        c_side;
  logic [32:0]               c_mag_x, c_mag_y, px_s, py_s;
  logic [30:0]               c_mul_x, c_mul_y;
  logic [pcp_pkg::DEN_W-1:0] c_den_x, c_den_y;
  logic signed [33:0]        du, dv;

  always_comb begin
    px_s = {cmd.point_x[31], cmd.point_x};
    py_s = {cmd.point_y[31], cmd.point_y};
    du   = {{2{cmd.pixel_u[31]}}, cmd.pixel_u} - {{2{cfg.center_x[31]}}, cfg.center_x};
    dv   = {{2{cmd.pixel_v[31]}}, cmd.pixel_v} - {{2{cfg.center_y[31]}}, cfg.center_y};
    c_side       = '0;
    c_side.vld   = in_vld;
    c_side.op    = cmd.op;
    c_side.depth = cmd.depth;
    if (cmd.op == pcp_pkg::OP_UNPROJ) begin
      // |pixel - center| * depth / focal
      c_side.bad   = cmd.depth[31] || (cmd.depth == '0);
      c_side.neg_x = du[33];
      c_side.neg_y = dv[33];
      c_mag_x      = du[33] ? 33'(-du) : du[32:0];
      c_mag_y      = dv[33] ? 33'(-dv) : dv[32:0];
      c_mul_x      = cmd.depth[30:0];
      c_mul_y      = cmd.depth[30:0];
      c_den_x      = cfg.focal_x;
      c_den_y      = cfg.focal_y;
    end else begin
      // focal * |point| / Z
      c_side.bad   = cmd.point_z[31] || (cmd.point_z == '0);
      c_side.neg_x = cmd.point_x[31];
      c_side.neg_y = cmd.point_y[31];
      c_mag_x      = px_s[32] ? -px_s : px_s;
      c_mag_y      = py_s[32] ? -py_s : py_s;
      c_mul_x      = cfg.focal_x;
      c_mul_y      = cfg.focal_y;
      c_den_x      = cmd.point_z[30:0];
      c_den_y      = cmd.point_z[30:0];
    end
    c_side.zero_x = (c_mag_x == '0) || (c_mul_x == '0);
    c_side.zero_y = (c_mag_y == '0) || (c_mul_y == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_side <= '0;
    end else begin
      s1_side <= c_side;
    end
    s1_mag_x <= c_mag_x;
    s1_mag_y <= c_mag_y;
    s1_mul_x <= c_mul_x;
    s1_mul_y <= c_mul_y;
    s1_den_x <= c_den_x;
    s1_den_y <= c_den_y;
  end

  // stage 2: numerator products
  always_ff @(posedge clk) begin
    if (rst) begin
      side <= '0;
    end else begin
      side <= s1_side;
    end
    num_x <= {31'd0, s1_mag_x} * {33'd0, s1_mul_x};
    num_y <= {31'd0, s1_mag_y} * {33'd0, s1_mul_y};
    den_x <= s1_den_x;
    den_y <= s1_den_y;
  end

endmodule

// ===== hdl/pcp_back.sv =====
// Sign, offset, bounds check and saturation after the dividers.
module pcp_back #(
  parameter int FRAC_BITS = pcp_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pcp_pkg::pcp_side_t        side,
  input  logic [pcp_pkg::NUM_W-1:0] quot_x,
  input  logic [pcp_pkg::NUM_W-1:0] quot_y,
  input  pcp_pkg::pcp_cfg_t         cfg,
  output logic                      res_vld,
  output pcp_pkg::pcp_out_t         res
);

  localparam int SW = pcp_pkg::SUM_W;
  localparam logic signed [31:0] MINUS_ONE = {{(32 - FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};
  localparam logic signed [SW-1:0] MAX32 = SW'(64'sh7FFFFFFF);
  localparam logic signed [SW-1:0] MIN32 = -SW'(64'sh80000000);

  pcp_pkg::pcp_side_t    b1_side;
  logic signed [SW-1:0]  b1_u, b1_v;
  logic signed [SW-1:0]  qs_x, qs_y, off_x, off_y;

  // stage 1: apply sign and add the principal point for projections
  always_comb begin
    qs_x = side.zero_x ? '0 : {2'b00, quot_x};
    qs_y = side.zero_y ? '0 : {2'b00, quot_y};
    if (side.neg_x) qs_x = -qs_x;
    if (side.neg_y) qs_y = -qs_y;
    off_x = '0;
    off_y = '0;
    if (side.op != pcp_pkg::OP_UNPROJ) begin
      off_x = SW'(cfg.center_x);
      off_y = SW'(cfg.center_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_side <= '0;
    end else begin
      b1_side <= side;
    end
    b1_u <= qs_x + off_x;
    b1_v <= qs_y + off_y;
  end

  // stage 2: checks and result word
  logic signed [SW-1:0] lim_u, lim_v;
  logic                 oob, sat_u, sat_v;
  logic signed [31:0]   cl_u, cl_v;
  pcp_pkg::pcp_out_t    r_next;

  always_comb begin
    lim_u = SW'({cfg.image_width, {FRAC_BITS{1'b0}}});
    lim_v = SW'({cfg.image_height, {FRAC_BITS{1'b0}}});
    oob   = b1_u[SW-1] || (b1_u >= lim_u) || b1_v[SW-1] || (b1_v >= lim_v);
    sat_u = (b1_u > MAX32) || (b1_u < MIN32);
    sat_v = (b1_v > MAX32) || (b1_v < MIN32);
    cl_u  = (b1_u > MAX32) ? 32'sh7FFFFFFF : (b1_u < MIN32) ? 32'sh80000000 : b1_u[31:0];
    cl_v  = (b1_v > MAX32) ? 32'sh7FFFFFFF : (b1_v < MIN32) ? 32'sh80000000 : b1_v[31:0];
    r_next = '0;
    case (b1_side.op)
      pcp_pkg::OP_PROJ, pcp_pkg::OP_PROJ_CHK: begin
        if (b1_side.bad) begin
          r_next.status = pcp_pkg::ST_NONPOS;
          if (b1_side.op == pcp_pkg::OP_PROJ_CHK) begin
            r_next.out_x = MINUS_ONE;
            r_next.out_y = MINUS_ONE;
          end
        end else if (b1_side.op == pcp_pkg::OP_PROJ_CHK && oob) begin
          r_next.out_x  = MINUS_ONE;
          r_next.out_y  = MINUS_ONE;
          r_next.status = pcp_pkg::ST_OOB;
        end else begin
          r_next.out_x  = cl_u;
          r_next.out_y  = cl_v;
          r_next.status = (sat_u || sat_v) ? pcp_pkg::ST_SAT : pcp_pkg::ST_OK;
        end
      end
      pcp_pkg::OP_UNPROJ: begin
        if (b1_side.bad) begin
          r_next.status = pcp_pkg::ST_NONPOS;
        end else begin
          r_next.out_x  = cl_u;
          r_next.out_y  = cl_v;
          r_next.out_z  = b1_side.depth;
          r_next.status = (sat_u || sat_v) ? pcp_pkg::ST_SAT : pcp_pkg::ST_OK;
        end
      end
      default: r_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else begin
      res_vld <= b1_side.vld;
    end
    res <= r_next;
  end

endmodule

// ===== hdl/pinhole_camera_projection.sv =====
// Top level of the pinhole camera projection and unprojection unit.
//
//  channel   handshake                      word
//  command   start (taken when !busy)       cmd    : pcp_in_t
//  result    result_valid, one-cycle strobe result : pcp_out_t
//  config    APB psel/penable/pwrite/pready focal, center, image size
//
// The pipeline has two setup/multiply stages, 32 divider stages (two quotient
// bits each) and two offset/check stages. One word enters per cycle.
// busy is held low; the pipeline never stalls since results cannot be held.
// Synchronous reset clears valid bits and loads the default camera registers.
module pinhole_camera_projection #(
  parameter int FRAC_BITS = pcp_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pcp_pkg::pcp_in_t  cmd,
  output logic              result_valid,
  output pcp_pkg::pcp_out_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  pcp_pkg::pcp_cfg_t cfg;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x      <= pcp_pkg::RST_FOCAL_X;
      cfg.focal_y      <= pcp_pkg::RST_FOCAL_Y;
      cfg.center_x     <= pcp_pkg::RST_CENTER_X;
      cfg.center_y     <= pcp_pkg::RST_CENTER_Y;
      cfg.image_width  <= pcp_pkg::RST_WIDTH;
      cfg.image_height <= pcp_pkg::RST_HEIGHT;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        pcp_pkg::REG_FOCAL_X:      cfg.focal_x      <= pwdata[30:0];
        pcp_pkg::REG_FOCAL_Y:      cfg.focal_y      <= pwdata[30:0];
        pcp_pkg::REG_CENTER_X:     cfg.center_x     <= pwdata;
        pcp_pkg::REG_CENTER_Y:     cfg.center_y     <= pwdata;
        pcp_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[15:0];
        pcp_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      pcp_pkg::REG_FOCAL_X:      prdata = {1'b0, cfg.focal_x};
      pcp_pkg::REG_FOCAL_Y:      prdata = {1'b0, cfg.focal_y};
      pcp_pkg::REG_CENTER_X:     prdata = cfg.center_x;
      pcp_pkg::REG_CENTER_Y:     prdata = cfg.center_y;
      pcp_pkg::REG_IMAGE_WIDTH:  prdata = {16'd0, cfg.image_width};
      pcp_pkg::REG_IMAGE_HEIGHT: prdata = {16'd0, cfg.image_height};
      default:                   prdata = '0;
    endcase
  end

  logic [pcp_pkg::NUM_W-1:0] num_x, num_y, quot_x, quot_y;
  logic [pcp_pkg::DEN_W-1:0] den_x, den_y;
  pcp_pkg::pcp_side_t        front_side;
  pcp_pkg::pcp_side_t        side_line [0:pcp_pkg::DIV_STAGES];

  pcp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_vld (start && !busy),
    .cmd    (cmd),
    .cfg    (cfg),
    .num_x  (num_x),
    .num_y  (num_y),
    .den_x  (den_x),
    .den_y  (den_y),
    .side   (front_side)
  );

  pcp_div u_div_x (.clk(clk), .num(num_x), .den(den_x), .quot(quot_x));
  pcp_div u_div_y (.clk(clk), .num(num_y), .den(den_y), .quot(quot_y));

  // control delay line matching the divider depth
  assign side_line[0] = front_side;
  for (genvar s = 0; s < pcp_pkg::DIV_STAGES; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side_line[s+1] <= '0;
      end else begin
        side_line[s+1] <= side_line[s];
      end
    end
  end

  pcp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .side    (side_line[pcp_pkg::DIV_STAGES]),
    .quot_x  (quot_x),
    .quot_y  (quot_y),
    .cfg     (cfg),
    .res_vld (result_valid),
    .res     (result)
  );

`ifndef SYNTHESIS
  localparam logic signed [31:0] A_MINUS_ONE =
    {{(32 - FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};

  // out of bounds always reports the -1,-1 pixel
  a_oob_word: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == pcp_pkg::ST_OOB |->
      result.out_x == A_MINUS_ONE && result.out_y == A_MINUS_ONE)
    else $error("out-of-bounds word without -1,-1");

  // rejected points never carry a depth
  a_nonpos_z: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == pcp_pkg::ST_NONPOS |-> result.out_z == '0)
    else $error("nonpositive word with nonzero Z");

  // a nonzero Z only comes from a good unprojection
  a_z_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.out_z != '0 |->
      result.status == pcp_pkg::ST_OK || result.status == pcp_pkg::ST_SAT)
    else $error("Z set on a rejected word");
`endif

endmodule
